// ===== hw/rtl/eight_neighbor_edge_weights_assert.svh =====
`ifndef EIGHT_NEIGHBOR_EDGE_WEIGHTS_ASSERT_SVH
`define EIGHT_NEIGHBOR_EDGE_WEIGHTS_ASSERT_SVH

// same-cycle implication, checked outside reset
`define ENEW_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define ENEW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/enew_pkg.sv =====
package enew_pkg;

    localparam int ENEW_MAX_WIDTH = 1024;

    localparam logic [15:0] ENEW_INV_SQRT2 = 16'd46341;
    localparam logic [24:0] ENEW_ONE_Q24   = 25'h1000000;
    localparam logic [23:0] ENEW_HALF_Q24  = 24'h800000;
    localparam logic [4:0]  ENEW_EXP_LIMIT = 5'd24;

    localparam logic [10:0] ENEW_RST_WIDTH = 11'd640;
    localparam logic [31:0] ENEW_RST_BETA  = 32'd0;
    localparam logic [15:0] ENEW_RST_GAMMA = 16'd12800;

    localparam logic [1:0] ENEW_CFG_WIDTH = 2'd0;
    localparam logic [1:0] ENEW_CFG_BETA  = 2'd1;
    localparam logic [1:0] ENEW_CFG_GAMMA = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIST,
        ST_BETA,
        ST_EXP_K,
        ST_EXP_I,
        ST_EXP_R,
        ST_GAIN,
        ST_OUT
    } t_state;

    // exp(-k), Q0.24
    function automatic logic [24:0] exp_int(input logic [4:0] k);
        logic [24:0] v;
        case (k)
            5'd0:    v = 25'd16777216;
            5'd1:    v = 25'd6171993;
            5'd2:    v = 25'd2270549;
            5'd3:    v = 25'd835288;
            5'd4:    v = 25'd307285;
            5'd5:    v = 25'd113044;
            5'd6:    v = 25'd41587;
            5'd7:    v = 25'd15299;
            5'd8:    v = 25'd5628;
            5'd9:    v = 25'd2070;
            5'd10:   v = 25'd762;
            5'd11:   v = 25'd280;
            5'd12:   v = 25'd103;
            5'd13:   v = 25'd38;
            5'd14:   v = 25'd14;
            5'd15:   v = 25'd5;
            5'd16:   v = 25'd2;
            5'd17:   v = 25'd1;
            default: v = 25'd0;
        endcase
        return v;
    endfunction

    // exp(-j/16), Q0.24
    function automatic logic [24:0] exp_sixteenth(input logic [3:0] j);
        logic [24:0] v;
        case (j)
            4'd0:    v = 25'd16777216;
            4'd1:    v = 25'd15760736;
            4'd2:    v = 25'd14805841;
            4'd3:    v = 25'd13908801;
            4'd4:    v = 25'd13066109;
            4'd5:    v = 25'd12274473;
            4'd6:    v = 25'd11530801;
            4'd7:    v = 25'd10832185;
            4'd8:    v = 25'd10175896;
            4'd9:    v = 25'd9559369;
            4'd10:   v = 25'd8980197;
            4'd11:   v = 25'd8436114;
            4'd12:   v = 25'd7924996;
            4'd13:   v = 25'd7444844;
            4'd14:   v = 25'd6993784;
            default: v = 25'd6570052;
        endcase
        return v;
    endfunction

    // exp(-i/256), Q0.24
    function automatic logic [24:0] exp_small(input logic [3:0] i);
        logic [24:0] v;
        case (i)
            4'd0:    v = 25'd16777216;
            4'd1:    v = 25'd16711808;
            4'd2:    v = 25'd16646655;
            4'd3:    v = 25'd16581756;
            4'd4:    v = 25'd16517109;
            4'd5:    v = 25'd16452715;
            4'd6:    v = 25'd16388572;
            4'd7:    v = 25'd16324679;
            4'd8:    v = 25'd16261035;
            4'd9:    v = 25'd16197640;
            4'd10:   v = 25'd16134491;
            4'd11:   v = 25'd16071589;
            4'd12:   v = 25'd16008931;
            4'd13:   v = 25'd15946518;
            4'd14:   v = 25'd15884349;
            default: v = 25'd15822422;
        endcase
        return v;
    endfunction

endpackage

// ===== hw/rtl/eight_neighbor_edge_weights.sv =====
// One word in, one word out; a new pixel is accepted only in the idle state, so o_in_stall
// stays high until the previous word has been loaded into the output register. A single shared
// 32x25 multiplier serves the beta, exponent and gain steps of each of the four weights, after the line store read.
// Reset (i_rst_n low, synchronous) clears control, pixel history and restores the
// register defaults; the line store is not cleared and holds garbage until written.
`include "eight_neighbor_edge_weights_assert.svh"

module eight_neighbor_edge_weights #(
    parameter int MAX_WIDTH = enew_pkg::ENEW_MAX_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    input  logic        i_frame_start,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [23:0] o_left_weight,
    output logic [23:0] o_upleft_weight,
    output logic [23:0] o_up_weight,
    output logic [23:0] o_upright_weight,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import enew_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int CW = (WW > 11) ? WW : 11;

    function automatic logic [17:0] dist2(input logic [23:0] p, input logic [23:0] q);
        logic signed [8:0]  d;
        logic signed [17:0] sq;
        logic [17:0]        s;
        s = '0;
        for (int c = 0; c < 3; c++) begin
            d  = $signed({1'b0, p[8*c +: 8]}) - $signed({1'b0, q[8*c +: 8]});
            sq = d * d;
            s  = s + $unsigned(sq);
        end
        return s;
    endfunction

    t_state      r_state, n_state;

    logic [10:0] r_image_width;
    logic [31:0] r_contrast_beta;
    logic [15:0] r_smooth_gamma;

    logic [AW-1:0] r_col;
    logic          r_first_row;
    logic [23:0]   r_left_pixel;
    logic [23:0]   r_upleft_pixel;
    logic [1:0]    r_lane;
    logic          r_out_valid;

    logic [23:0] r_row_store [MAX_WIDTH];
    logic [23:0] r_up_rd;
    logic [23:0] r_upright_rd;

    logic [23:0] r_cur;
    logic [23:0] r_nb [4];
    logic [3:0]  r_en;
    logic [31:0] r_g_diag;
    logic [17:0] r_d2;
    logic        r_over;
    logic [28:0] r_a;
    logic [24:0] r_e;
    logic [23:0] r_w [4];
    logic [23:0] r_left_weight, r_upleft_weight, r_up_weight, r_upright_weight;

    logic          accept;
    logic          out_load;
    logic [23:0]   cur;
    logic [CW-1:0] cfg_w_ext;
    logic [WW-1:0] w_eff;
    logic [AW-1:0] x;
    logic [WW-1:0] x1;
    logic          fr;
    logic          last;
    logic [AW-1:0] ra1;

    logic [31:0] mul_a;
    logic [24:0] mul_b;
    logic [56:0] mul_p;
    logic [56:0] rnd24;
    logic [57:0] rnd32;
    logic [24:0] e_next;

    assign cur       = {i_red, i_green, i_blue};
    assign cfg_w_ext = CW'(r_image_width);

    always_comb begin
        if (cfg_w_ext == '0) begin
            w_eff = WW'(1);
        end else if (cfg_w_ext > CW'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(cfg_w_ext);
        end
    end

    assign x    = i_frame_start ? '0 : r_col;
    assign fr   = i_frame_start | r_first_row;
    assign x1   = WW'(x) + WW'(1);
    assign last = !(x1 < w_eff);
    assign ra1  = last ? x : x1[AW-1:0];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (i_in_valid) n_state = ST_LOAD;
            ST_LOAD:  n_state = ST_DIST;
            ST_DIST:  n_state = ST_BETA;
            ST_BETA:  n_state = ST_EXP_K;
            ST_EXP_K: n_state = ST_EXP_I;
            ST_EXP_I: n_state = ST_EXP_R;
            ST_EXP_R: n_state = ST_GAIN;
            ST_GAIN:  n_state = (r_lane == 2'd3) ? ST_OUT : ST_DIST;
            ST_OUT:   if (!r_out_valid || !i_out_stall) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = 1'b1;
        accept     = 1'b0;
        out_load   = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                accept     = i_in_valid;
            end
            ST_BETA: begin
                mul_a = r_contrast_beta;
                mul_b = 25'(r_d2);
            end
            ST_EXP_K: begin
                mul_a = 32'(exp_int(r_a[28:24]));
                mul_b = exp_sixteenth(r_a[23:20]);
            end
            ST_EXP_I: begin
                mul_a = 32'(r_e);
                mul_b = exp_small(r_a[19:16]);
            end
            ST_EXP_R: begin
                mul_a = 32'(r_e);
                mul_b = ENEW_ONE_Q24 - 25'(r_a[15:0]);
            end
            ST_GAIN: begin
                mul_a = r_lane[0] ? r_g_diag : {r_smooth_gamma, 16'h0};
                mul_b = r_e;
            end
            ST_OUT: begin
                out_load = !r_out_valid || !i_out_stall;
            end
            default: begin
            end
        endcase
    end

    assign mul_p  = 57'(mul_a) * 57'(mul_b);
    assign rnd24  = mul_p + 57'(ENEW_HALF_Q24);
    assign e_next = rnd24[48:24];
    assign rnd32  = 58'(mul_p) + (58'(1) << 31);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_image_width   <= ENEW_RST_WIDTH;
            r_contrast_beta <= ENEW_RST_BETA;
            r_smooth_gamma  <= ENEW_RST_GAMMA;
            r_col           <= '0;
            r_first_row     <= 1'b1;
            r_left_pixel    <= '0;
            r_upleft_pixel  <= '0;
            r_lane          <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    ENEW_CFG_WIDTH: r_image_width   <= i_cfg_data[10:0];
                    ENEW_CFG_BETA:  r_contrast_beta <= i_cfg_data;
                    ENEW_CFG_GAMMA: r_smooth_gamma  <= i_cfg_data[15:0];
                    default: begin
                    end
                endcase
            end
            if (accept) begin
                r_col        <= last ? '0 : x1[AW-1:0];
                r_first_row  <= last ? 1'b0 : fr;
                r_left_pixel <= cur;
            end
            if (r_state == ST_LOAD) begin
                r_upleft_pixel <= r_up_rd;
                r_lane         <= '0;
            end
            if (r_state == ST_GAIN) begin
                r_lane <= r_lane + 2'd1;
            end
            r_out_valid <= out_load || (r_out_valid && i_out_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_row_store[x] <= cur;
            r_up_rd        <= r_row_store[x];
            r_upright_rd   <= r_row_store[ra1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cur    <= cur;
            r_nb[0]  <= r_left_pixel;
            r_nb[1]  <= r_upleft_pixel;
            r_en[0]  <= (x != '0);
            r_en[1]  <= (x != '0) && !fr;
            r_en[2]  <= !fr;
            r_en[3]  <= !fr && !last;
            r_g_diag <= 32'(r_smooth_gamma) * 32'(ENEW_INV_SQRT2);
        end
        case (r_state)
            ST_LOAD: begin
                r_nb[2] <= r_up_rd;
                r_nb[3] <= r_upright_rd;
            end
            ST_DIST:  r_d2 <= dist2(r_cur, r_nb[r_lane]);
            ST_BETA: begin
                r_over <= mul_p > 57'({ENEW_EXP_LIMIT, 24'h0});
                r_a    <= mul_p[28:0];
            end
            ST_EXP_K: r_e <= r_over ? '0 : e_next;
            ST_EXP_I: r_e <= e_next;
            ST_EXP_R: r_e <= e_next;
            ST_GAIN:  r_w[r_lane] <= r_en[r_lane] ? rnd32[55:32] : '0;
            default: begin
            end
        endcase
        if (out_load) begin
            r_left_weight    <= r_w[0];
            r_upleft_weight  <= r_w[1];
            r_up_weight      <= r_w[2];
            r_upright_weight <= r_w[3];
        end
    end

    assign o_cfg_ready      = 1'b1;
    assign o_out_valid      = r_out_valid;
    assign o_left_weight    = r_left_weight;
    assign o_upleft_weight  = r_upleft_weight;
    assign o_up_weight      = r_up_weight;
    assign o_upright_weight = r_upright_weight;

    `ENEW_ASSERT_NEXT(a_accept_to_load, accept, r_state == ST_LOAD, "accept did not start a read")
    `ENEW_ASSERT_NEXT(a_out_hold, r_out_valid && i_out_stall, r_out_valid, "stalled word dropped")
    `ENEW_ASSERT_NEXT(a_out_load, out_load, r_out_valid && r_state == ST_IDLE,
                      "finished word not presented")
    `ENEW_ASSERT_NOW(a_lane_reset, r_state == ST_DIST && $past(r_state) == ST_LOAD,
                     r_lane == 2'd0, "lane counter not cleared")

endmodule

// ===== tb/eight_neighbor_edge_weights_tb.sv =====
`timescale 1ns / 1ps

module eight_neighbor_edge_weights_tb;
    import enew_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 2_000_000;
    localparam int unsigned RANDOM_PIXELS = 120;
    localparam int unsigned DRAIN_CYCLES = 60;
    localparam int unsigned MAX_PRINTED = 50;
    localparam logic [1:0] CFG_SPARE = 2'd3;
    localparam longint unsigned STRAIGHT_SCALE = 64'd65536;
    localparam longint unsigned DIAG_SCALE = 64'd46341;
    localparam longint unsigned Q24_ONE = 64'd16777216;
    localparam longint unsigned Q24_HALF = 64'd8388608;
    localparam longint unsigned EXP_CUTOFF_Q24 = 64'd24 << 24;

    typedef struct packed {
        logic [23:0] left;
        logic [23:0] upleft;
        logic [23:0] up;
        logic [23:0] upright;
    } t_edge_weights;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_red;
    logic [7:0]  i_green;
    logic [7:0]  i_blue;
    logic        i_frame_start;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [23:0] o_left_weight;
    logic [23:0] o_upleft_weight;
    logic [23:0] o_up_weight;
    logic [23:0] o_upright_weight;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    eight_neighbor_edge_weights dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_red            (i_red),
        .i_green          (i_green),
        .i_blue           (i_blue),
        .i_frame_start    (i_frame_start),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_left_weight    (o_left_weight),
        .o_upleft_weight  (o_upleft_weight),
        .o_up_weight      (o_up_weight),
        .o_upright_weight (o_upright_weight),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    // exp(-k), exp(-j/16), exp(-i/256) in Q0.24
    logic [24:0] exp_whole [0:24] = '{
        25'd16777216, 25'd6171993, 25'd2270549, 25'd835288, 25'd307285,
        25'd113044, 25'd41587, 25'd15299, 25'd5628, 25'd2070, 25'd762,
        25'd280, 25'd103, 25'd38, 25'd14, 25'd5, 25'd2, 25'd1,
        25'd0, 25'd0, 25'd0, 25'd0, 25'd0, 25'd0, 25'd0
    };
    logic [24:0] exp_sixteenths [0:15] = '{
        25'd16777216, 25'd15760736, 25'd14805841, 25'd13908801,
        25'd13066109, 25'd12274473, 25'd11530801, 25'd10832185,
        25'd10175896, 25'd9559369, 25'd8980197, 25'd8436114,
        25'd7924996, 25'd7444844, 25'd6993784, 25'd6570052
    };
    logic [24:0] exp_fine [0:15] = '{
        25'd16777216, 25'd16711808, 25'd16646655, 25'd16581756,
        25'd16517109, 25'd16452715, 25'd16388572, 25'd16324679,
        25'd16261035, 25'd16197640, 25'd16134491, 25'd16071589,
        25'd16008931, 25'd15946518, 25'd15884349, 25'd15822422
    };

    logic [10:0] pred_width = ENEW_RST_WIDTH;
    logic [31:0] pred_beta = ENEW_RST_BETA;
    logic [15:0] pred_gamma = ENEW_RST_GAMMA;
    logic [23:0] line_mem [0:ENEW_MAX_WIDTH-1];
    logic [23:0] prev_px = '0;
    logic [23:0] diag_px = '0;
    int unsigned col_idx = 0;
    bit          top_row = 1'b1;

    t_edge_weights expected_weights[$];
    int unsigned   mismatch_count = 0;
    int unsigned   results_seen = 0;
    int unsigned   cycle_count = 0;
    int unsigned   out_hold_cycles = 0;
    int unsigned   stall_run = 0;
    bit            steady_sender = 1'b0;
    logic [23:0]   walk_px = '0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int unsigned color_dist2(input logic [23:0] p, input logic [23:0] q);
        int unsigned sum;
        int d;
        sum = 0;
        for (int c = 0; c < 3; c++) begin
            d = int'(p[c*8 +: 8]) - int'(q[c*8 +: 8]);
            sum += d * d;
        end
        return sum;
    endfunction

    function automatic longint unsigned round_q24(input longint unsigned x);
        return (x + Q24_HALF) >> 24;
    endfunction

    function automatic longint unsigned neg_exp_q24(input int unsigned d2);
        longint unsigned arg;
        longint unsigned e;
        arg = pred_beta;
        arg = arg * d2;
        if (arg > EXP_CUTOFF_Q24)
            return 0;
        e = exp_whole[arg[28:24]];
        e = round_q24(e * exp_sixteenths[arg[23:20]]);
        e = round_q24(e * exp_fine[arg[19:16]]);
        e = round_q24(e * (Q24_ONE - arg[15:0]));
        return e;
    endfunction

    function automatic logic [23:0] edge_weight(input logic [23:0] p, input logic [23:0] q,
                                                input longint unsigned scale);
        longint unsigned g;
        longint unsigned w;
        g = pred_gamma;
        g = g * scale;
        w = (g * neg_exp_q24(color_dist2(p, q)) + 64'h8000_0000) >> 32;
        return w[23:0];
    endfunction

    function automatic t_edge_weights predict_weights(input logic [23:0] px, input bit fs);
        t_edge_weights r;
        int unsigned w;
        int unsigned x;
        logic [23:0] above;
        w = pred_width;
        if (w == 0)
            w = 1;
        if (w > ENEW_MAX_WIDTH)
            w = ENEW_MAX_WIDTH;
        if (fs) begin
            col_idx = 0;
            top_row = 1'b1;
        end
        x = col_idx;
        above = line_mem[x];
        r = '0;
        if (x > 0)
            r.left = edge_weight(px, prev_px, STRAIGHT_SCALE);
        if (x > 0 && !top_row)
            r.upleft = edge_weight(px, diag_px, DIAG_SCALE);
        if (!top_row)
            r.up = edge_weight(px, above, STRAIGHT_SCALE);
        if (!top_row && x + 1 < w)
            r.upright = edge_weight(px, line_mem[x + 1], DIAG_SCALE);
        diag_px = above;
        line_mem[x] = px;
        prev_px = px;
        if (x + 1 >= w) begin
            col_idx = 0;
            top_row = 1'b0;
        end else begin
            col_idx = x + 1;
        end
        return r;
    endfunction

    function automatic int unsigned effective_width();
        if (pred_width == 0)
            return 1;
        if (pred_width > ENEW_MAX_WIDTH)
            return ENEW_MAX_WIDTH;
        return pred_width;
    endfunction

    function automatic logic [23:0] next_pixel(input logic [23:0] prev);
        logic [23:0] px;
        int v;
        int unsigned r;
        r = $urandom_range(0, 99);
        px = 24'($urandom);
        if (r < 15)
            return px;
        for (int c = 0; c < 3; c++) begin
            if (r < 22)
                v = $urandom_range(0, 1) ? 255 : 0;
            else
                v = int'(prev[c*8 +: 8]) + int'($urandom_range(0, 8)) - 4;
            if (v < 0)
                v = 0;
            if (v > 255)
                v = 255;
            px[c*8 +: 8] = v[7:0];
        end
        return px;
    endfunction

    function automatic logic [31:0] width_word(input logic [10:0] w);
        logic [31:0] d;
        d = $urandom;
        d[10:0] = w;
        return d;
    endfunction

    function automatic logic [31:0] gamma_word(input logic [15:0] g);
        logic [31:0] d;
        d = $urandom;
        d[15:0] = g;
        return d;
    endfunction

    function automatic logic [31:0] pick_beta();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return 32'd0;
        if (r < 10)
            return 32'hFFFF_FFFF;
        if (r < 40)
            return $urandom_range(1, 1 << 16);
        if (r < 75)
            return $urandom_range(1, 1 << 21);
        if (r < 92)
            return $urandom_range(1 << 21, 1 << 25);
        return $urandom;
    endfunction

    function automatic logic [15:0] pick_gamma();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 16'd0;
        if (r < 20)
            return 16'hFFFF;
        return 16'($urandom_range(0, 65535));
    endfunction

    function automatic logic [10:0] pick_width();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 11'($urandom_range(1, 16));
        if (r < 65)
            return 11'($urandom_range(17, 80));
        if (r < 80)
            return 11'($urandom_range(2, 8));
        if (r < 90)
            return 11'($urandom_range(0, 1));
        if (r < 95)
            return 11'd1024;
        return 11'($urandom_range(1025, 2047));
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 4);
        if (r < 96)
            return $urandom_range(5, 27);
        return $urandom_range(30, 100);
    endfunction

    task automatic report_mismatch(input string what, input logic [23:0] want,
                                   input logic [23:0] got);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("word %0d: %s expected %0d, got %0d", results_seen, what, want, got);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            ENEW_CFG_WIDTH: pred_width = data[10:0];
            ENEW_CFG_BETA:  pred_beta = data;
            ENEW_CFG_GAMMA: pred_gamma = data[15:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_pixel(input logic [23:0] px, input bit fs);
        int unsigned gap;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_red <= px[23:16];
        i_green <= px[15:8];
        i_blue <= px[7:0];
        i_frame_start <= fs;
        do @(posedge i_clk); while (o_in_stall);
        expected_weights.push_back(predict_weights(px, fs));
        gap = steady_sender ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_weights.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic test_reset_state();
        send_pixel(24'h000000, 1'b0);
        send_pixel(24'hFFFFFF, 1'b0);
        send_pixel(24'h11C803, 1'b0);
    endtask

    task automatic test_frame_borders();
        logic [23:0] colors [0:9];
        colors = '{24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF,
                   24'h808080, 24'h7F7F7F, 24'h010101, 24'hFEFEFE, 24'h00FFFF};
        wait_idle();
        write_reg(ENEW_CFG_WIDTH, width_word(11'd4));
        write_reg(ENEW_CFG_BETA, 32'h0002_0000);
        write_reg(ENEW_CFG_GAMMA, gamma_word(16'hFFFF));
        for (int i = 0; i < 10; i++)
            send_pixel(colors[i], i == 0);
    endtask

    task automatic test_exp_range();
        wait_idle();
        write_reg(ENEW_CFG_WIDTH, width_word(11'd3));
        write_reg(ENEW_CFG_BETA, 32'h0100_0000);
        write_reg(CFG_SPARE, $urandom);
        send_pixel(24'h000000, 1'b1);
        send_pixel(24'h000001, 1'b0);
        send_pixel(24'h000101, 1'b0);
        send_pixel(24'h020202, 1'b0);
        send_pixel(24'h030303, 1'b0);
        wait_idle();
        write_reg(ENEW_CFG_BETA, 32'hFFFF_FFFF);
        send_pixel(24'h030303, 1'b0);
        send_pixel(24'h020202, 1'b0);
        wait_idle();
        write_reg(ENEW_CFG_GAMMA, gamma_word(16'd0));
        send_pixel(24'h030303, 1'b0);
    endtask

    task automatic test_width_limits();
        wait_idle();
        write_reg(ENEW_CFG_WIDTH, width_word(11'd0));
        write_reg(ENEW_CFG_BETA, $urandom_range(1, 1 << 18));
        write_reg(ENEW_CFG_GAMMA, gamma_word(pick_gamma()));
        for (int i = 0; i < 4; i++) begin
            walk_px = next_pixel(walk_px);
            send_pixel(walk_px, i == 0);
        end
    endtask

    task automatic test_width_shrink();
        wait_idle();
        write_reg(ENEW_CFG_WIDTH, width_word(11'd4));
        for (int i = 0; i < 7; i++) begin
            walk_px = next_pixel(walk_px);
            send_pixel(walk_px, i == 0);
        end
        // end the row early: column count is already past the new width
        wait_idle();
        write_reg(ENEW_CFG_WIDTH, width_word(11'd2));
        for (int i = 0; i < 3; i++) begin
            walk_px = next_pixel(walk_px);
            send_pixel(walk_px, 1'b0);
        end
    endtask

    task automatic test_widest_row();
        wait_idle();
        write_reg(ENEW_CFG_WIDTH, width_word(11'h7FF));
        write_reg(ENEW_CFG_BETA, $urandom_range(1, 1 << 20));
        write_reg(ENEW_CFG_GAMMA, gamma_word(pick_gamma()));
        for (int i = 0; i < ENEW_MAX_WIDTH + 6; i++) begin
            walk_px = next_pixel(walk_px);
            send_pixel(walk_px, i == 0);
        end
    endtask

    task automatic test_output_backpressure();
        wait_idle();
        write_reg(ENEW_CFG_WIDTH, width_word(11'd5));
        write_reg(ENEW_CFG_BETA, $urandom_range(1, 1 << 20));
        steady_sender = 1'b1;
        out_hold_cycles = 600;
        for (int i = 0; i < 20; i++) begin
            walk_px = next_pixel(walk_px);
            send_pixel(walk_px, i == 0);
        end
        steady_sender = 1'b0;
    endtask

    task automatic test_random_images();
        int unsigned sent;
        int unsigned w;
        int unsigned n;
        bit keep;
        bit fs;
        sent = 0;
        while (sent < RANDOM_PIXELS) begin
            wait_idle();
            keep = ($urandom_range(0, 3) == 0);
            if (!keep)
                write_reg(ENEW_CFG_WIDTH, width_word(pick_width()));
            if ($urandom_range(0, 9) < 7)
                write_reg(ENEW_CFG_BETA, pick_beta());
            if ($urandom_range(0, 9) < 7)
                write_reg(ENEW_CFG_GAMMA, gamma_word(pick_gamma()));
            steady_sender = ($urandom_range(0, 3) == 0);
            w = effective_width();
            if (w > 100)
                n = $urandom_range(5, 30);
            else
                n = w * $urandom_range(2, 4) + $urandom_range(0, w);
            if (n > RANDOM_PIXELS - sent)
                n = RANDOM_PIXELS - sent;
            for (int i = 0; i < n; i++) begin
                // a new width always starts a new image
                fs = (i == 0 && !keep) || ($urandom_range(0, 49) == 0);
                walk_px = next_pixel(walk_px);
                send_pixel(walk_px, fs);
                sent++;
            end
        end
        steady_sender = 1'b0;
    endtask

    always @(negedge i_clk) begin : drive_out_stall
        int unsigned r;
        if (out_hold_cycles > 0) begin
            i_out_stall <= 1'b1;
            out_hold_cycles--;
        end else if (stall_run > 0) begin
            stall_run--;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
                i_out_stall <= 1'b0;
                stall_run = $urandom_range(0, 6);
            end else if (r < 85) begin
                i_out_stall <= 1'b1;
                stall_run = $urandom_range(0, 3);
            end else if (r < 95) begin
                i_out_stall <= 1'b0;
                stall_run = $urandom_range(20, 150);
            end else begin
                i_out_stall <= 1'b1;
                stall_run = $urandom_range(10, 60);
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        t_edge_weights want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (expected_weights.size() == 0) begin
                report_mismatch("unexpected word", 24'd0, o_left_weight);
            end else begin
                want = expected_weights.pop_front();
                if (o_left_weight !== want.left)
                    report_mismatch("left_weight", want.left, o_left_weight);
                if (o_upleft_weight !== want.upleft)
                    report_mismatch("upleft_weight", want.upleft, o_upleft_weight);
                if (o_up_weight !== want.up)
                    report_mismatch("up_weight", want.up, o_up_weight);
                if (o_upright_weight !== want.upright)
                    report_mismatch("upright_weight", want.upright, o_upright_weight);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_red = '0;
        i_green = '0;
        i_blue = '0;
        i_frame_start = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = ENEW_CFG_WIDTH;
        i_cfg_data = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_frame_borders();
        test_exp_range();
        test_width_limits();
        test_width_shrink();
        test_output_backpressure();
        test_widest_row();
        test_random_images();

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
